@@ rtl/core/npc_pkg.sv @@
// ----------------------------------------------------------------------------
// npc_pkg: shared types and constants for the nearest palette color block
// Holds the cube constants, the candidate and distance beat types and the
// controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned LvlW      = 3;
  localparam int unsigned SqW       = 2 * ChanW;
  localparam int unsigned BaseW     = SqW + 4;
  localparam int unsigned DiffW     = SqW + 2;
  localparam int unsigned ProdW     = DiffW + ChanW + 1;
  localparam int unsigned QuotW     = SqW + 2;
  localparam int unsigned DistW     = BaseW + 1;
  localparam int unsigned MeanShift = 8;

  localparam logic [LvlW-1:0] LastLevel = 3'd5;
  localparam logic [IdxW-1:0] CubeBase  = 8'd8;
  localparam logic [ChanW-1:0] CubeStep = 8'd51;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } npc_state_e;

  // One cube candidate on its way into the distance pipeline.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IdxW-1:0]  idx;
    logic [ChanW-1:0] r_lvl;
    logic [ChanW-1:0] g_lvl;
    logic [ChanW-1:0] b_lvl;
  } cand_t;

  // One finished distance leaving the pipeline.
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic [IdxW-1:0]         idx;
    logic signed [DistW-1:0] dist_val;
  } dist_res_t;

  // Channel value of a cube level: level times the cube step.
  function automatic logic [ChanW-1:0] level_value(input logic [LvlW-1:0] lvl);
    logic [ChanW-1:0] val;
    case (lvl)
      3'd0:    val = 8'd0;
      3'd1:    val = CubeStep;
      3'd2:    val = 8'd102;
      3'd3:    val = 8'd153;
      3'd4:    val = 8'd204;
      3'd5:    val = 8'd255;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/npc_seq.sv @@
// ----------------------------------------------------------------------------
// npc_seq: cube candidate sequencer
// Walks the 216 cube entries in index order, one candidate per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output npc_pkg::cand_t     cand_o
);
  import npc_pkg::*;

  logic            run_q, run_d;
  logic [LvlW-1:0] ri_q, ri_d, gi_q, gi_d, bi_q, bi_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            last_c;

  assign last_c = (ri_q == LastLevel) && (gi_q == LastLevel) && (bi_q == LastLevel);

  always_comb begin
    run_d = run_q;
    ri_d  = ri_q;
    gi_d  = gi_q;
    bi_d  = bi_q;
    idx_d = idx_q;
    if (start_i) begin
      run_d = 1'b1;
      ri_d  = '0;
      gi_d  = '0;
      bi_d  = '0;
      idx_d = CubeBase;
    end else if (run_q) begin
      idx_d = idx_q + 8'd1;
      if (bi_q != LastLevel) begin
        bi_d = bi_q + 3'd1;
      end else begin
        bi_d = '0;
        if (gi_q != LastLevel) begin
          gi_d = gi_q + 3'd1;
        end else begin
          gi_d = '0;
          ri_d = ri_q + 3'd1;
        end
      end
      if (last_c) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      ri_q  <= '0;
      gi_q  <= '0;
      bi_q  <= '0;
      idx_q <= CubeBase;
    end else begin
      run_q <= run_d;
      ri_q  <= ri_d;
      gi_q  <= gi_d;
      bi_q  <= bi_d;
      idx_q <= idx_d;
    end
  end

  always_comb begin
    cand_o.valid = run_q;
    cand_o.last  = last_c;
    cand_o.idx   = idx_q;
    cand_o.r_lvl = level_value(ri_q);
    cand_o.g_lvl = level_value(gi_q);
    cand_o.b_lvl = level_value(bi_q);
  end

endmodule

`default_nettype wire

@@ rtl/core/npc_dist.sv @@
// ----------------------------------------------------------------------------
// npc_dist: redmean distance pipeline
// Three stages: squared differences, weighted sum and mean product, then the
// truncating divide by 256 and the final sum. One candidate enters per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_dist (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [npc_pkg::ChanW-1:0]    red_i,
  input  wire logic [npc_pkg::ChanW-1:0]    green_i,
  input  wire logic [npc_pkg::ChanW-1:0]    blue_i,
  input  npc_pkg::cand_t                    cand_i,
  output npc_pkg::dist_res_t                res_o
);
  import npc_pkg::*;

  // Magnitude of the difference of two channel values.
  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    logic [ChanW:0] d;
    d = {1'b0, a} - {1'b0, b};
    return d[ChanW] ? ChanW'(-d) : d[ChanW-1:0];
  endfunction

  // Stage 1 registers.
  logic             v1_q, last1_q;
  logic [IdxW-1:0]  idx1_q;
  logic [SqW-1:0]   dr1_q, dg1_q, db1_q;
  logic [ChanW-1:0] mean1_q;
  logic [ChanW-1:0] ar_c, ag_c, ab_c;
  logic [ChanW:0]   rsum_c;

  // Stage 2 registers.
  logic                    v2_q, last2_q;
  logic [IdxW-1:0]         idx2_q;
  logic [BaseW-1:0]        base2_q;
  logic signed [ProdW-1:0] prod2_q;
  logic signed [DiffW-1:0] rb_diff_c;
  logic signed [ProdW-1:0] prod_c;
  logic [BaseW-1:0]        base_c;

  // Stage 3 registers.
  logic                    v3_q, last3_q;
  logic [IdxW-1:0]         idx3_q;
  logic signed [DistW-1:0] dist3_q;
  logic signed [ProdW-1:0] prod_adj_c, quot_full_c;
  logic signed [DistW-1:0] dist_c;

  assign ar_c   = abs_diff(red_i, cand_i.r_lvl);
  assign ag_c   = abs_diff(green_i, cand_i.g_lvl);
  assign ab_c   = abs_diff(blue_i, cand_i.b_lvl);
  assign rsum_c = {1'b0, red_i} + {1'b0, cand_i.r_lvl};

  assign base_c    = {3'b000, dr1_q, 1'b0} + {2'b00, dg1_q, 2'b00}
                   + {4'b0000, db1_q} + {3'b000, db1_q, 1'b0};
  assign rb_diff_c = $signed({2'b00, dr1_q}) - $signed({2'b00, db1_q});
  assign prod_c    = ProdW'($signed({1'b0, mean1_q})) * ProdW'(rb_diff_c);

  // Division by 256 toward zero: bias negative products before the shift.
  assign prod_adj_c  = prod2_q + (prod2_q[ProdW-1] ? ProdW'(255) : ProdW'(0));
  assign quot_full_c = prod_adj_c >>> MeanShift;
  assign dist_c      = $signed({1'b0, base2_q})
                     + $signed({{(DistW-QuotW){quot_full_c[QuotW-1]}},
                                quot_full_c[QuotW-1:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cand_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    last1_q <= cand_i.last;
    idx1_q  <= cand_i.idx;
    dr1_q   <= SqW'(ar_c) * SqW'(ar_c);
    dg1_q   <= SqW'(ag_c) * SqW'(ag_c);
    db1_q   <= SqW'(ab_c) * SqW'(ab_c);
    mean1_q <= rsum_c[ChanW:1];
    last2_q <= last1_q;
    idx2_q  <= idx1_q;
    base2_q <= base_c;
    prod2_q <= prod_c;
    last3_q <= last2_q;
    idx3_q  <= idx2_q;
    dist3_q <= dist_c;
  end

  always_comb begin
    res_o.valid    = v3_q;
    res_o.last     = last3_q;
    res_o.idx      = idx3_q;
    res_o.dist_val = dist3_q;
  end

endmodule

`default_nettype wire

@@ rtl/core/npc_best.sv @@
// ----------------------------------------------------------------------------
// npc_best: running minimum tracker
// Keeps the smallest distance seen in a scan and the index that produced it.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_best (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  npc_pkg::dist_res_t              res_i,
  output logic [npc_pkg::IdxW-1:0]        best_idx_o,
  output logic                            done_o
);
  import npc_pkg::*;

  logic                    have_q;
  logic                    done_q;
  logic [IdxW-1:0]         idx_q;
  logic signed [DistW-1:0] dist_q;
  logic                    take_c;

  // Only a strictly smaller distance replaces the best, so the earliest wins ties.
  assign take_c = res_i.valid && (!have_q || (res_i.dist_val < dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= res_i.valid && res_i.last;
      if (start_i) begin
        have_q <= 1'b0;
      end else if (res_i.valid) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_c) begin
      idx_q  <= res_i.idx;
      dist_q <= res_i.dist_val;
    end
  end

  assign best_idx_o = idx_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

@@ rtl/core/nearest_palette_color_top.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_top: nearest 6x6x6 cube color by redmean distance
// Matches one RGB color against the 216 cube entries and returns the index
// of the closest one, or zero when color matching is switched off.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   -------   ------------------------   ------------------------------
//   input     in_valid_i / in_stall_o    red_i, green_i, blue_i
//   output    out_valid_o / out_stall_i  palette_index_o
//   config    cfg_we_i                   cfg_wdata_i (colors_enabled)
//
// An enabled beat goes from acceptance to the result register in steps: a
// start, a scan in which the sequencer feeds one candidate per cycle over
// the 216 cube entries into the shared distance pipeline, three pipeline
// stages, a compare and a load of the result. With colors disabled a beat
// skips the scan and goes straight to the load.
// Reset sets colors_enabled to one and empties the block; no sweep is needed.
// The input is stalled for the whole scan. A finished result sits in the
// output register, so a new beat is accepted while the last one still waits;
// a result that cannot be loaded holds the controller until the output frees.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_top (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [npc_pkg::ChanW-1:0] red_i,
  input  wire logic [npc_pkg::ChanW-1:0] green_i,
  input  wire logic [npc_pkg::ChanW-1:0] blue_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [npc_pkg::IdxW-1:0]      palette_index_o
);
  import npc_pkg::*;

  npc_state_e state_q, state_d;

  logic             colors_en_q;
  logic             zero_q, zero_d;
  logic [ChanW-1:0] red_q, green_q, blue_q;
  logic             out_valid_q, out_valid_d;
  logic [IdxW-1:0]  out_idx_q, out_idx_d;

  logic            in_accept_c;
  logic            start_c;
  logic            load_c;
  logic            out_free_c;
  cand_t           cand;
  dist_res_t       res;
  logic [IdxW-1:0] best_idx;
  logic            scan_done;

  assign in_accept_c = in_valid_i && !in_stall_o;
  assign start_c     = in_accept_c && colors_en_q;
  assign out_free_c  = !out_valid_q || !out_stall_i;

  // The colors_enabled register. Configuration must only change while idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colors_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      colors_en_q <= cfg_wdata_i;
    end
  end

  // The color under test is held for the whole scan.
  always_ff @(posedge clk_i) begin
    if (in_accept_c) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
  end

  npc_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_c),
    .cand_o  (cand)
  );

  npc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .red_i   (red_q),
    .green_i (green_q),
    .blue_i  (blue_q),
    .cand_i  (cand),
    .res_o   (res)
  );

  npc_best u_best (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_c),
    .res_i      (res),
    .best_idx_o (best_idx),
    .done_o     (scan_done)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept_c) begin
          state_d = colors_en_q ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free_c) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_stall_o = 1'b1;
    load_c     = 1'b0;
    case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_SCAN:   in_stall_o = 1'b1;
      ST_FINISH: load_c     = out_free_c;
      default:   in_stall_o = 1'b1;
    endcase
  end

  // The disabled case remembers to report index zero.
  assign zero_d = in_accept_c ? !colors_en_q : zero_q;

  // Output register: loads the result, clears once the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load_c) begin
      out_valid_d = 1'b1;
      out_idx_d   = zero_q ? '0 : best_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q <= out_idx_d;
  end

  assign out_valid_o     = out_valid_q;
  assign palette_index_o = out_idx_q;

endmodule

`default_nettype wire
